// ===== src/art_pkg.sv =====
`timescale 1ns / 1ps
// Package for the acknowledgement retry tracker.
// Holds the beat types, command and status codes and default sizes; no dependencies.
package art_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int RESULT_CAP      = 16;

  localparam logic [2:0] CMD_TRACK = 3'd0;
  localparam logic [2:0] CMD_ACK   = 3'd1;
  localparam logic [2:0] CMD_SCAN  = 3'd2;
  localparam logic [2:0] CMD_RETRY = 3'd3;
  localparam logic [2:0] CMD_DRAIN = 3'd4;
  localparam logic [2:0] CMD_COUNT = 3'd5;
  localparam logic [2:0] CMD_PURGE = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_COUNT = 2'd3;

  localparam logic [0:0] REG_RETRY_LIMIT = 1'b0;
  localparam logic [0:0] REG_ACK_TIMEOUT = 1'b1;

  localparam logic [2:0]  RETRY_LIMIT_RST = 3'd3;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd30;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] message_id;
    logic [31:0] user_id;
    logic [31:0] payload_ref;
    logic [15:0] target_handle;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_message_id;
    logic [31:0] out_user_id;
    logic [31:0] out_payload_ref;
    logic [15:0] out_target_handle;
    logic [2:0]  out_tries;
    logic [4:0]  pending_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] message_id;
    logic [31:0] user_id;
    logic [31:0] payload_ref;
    logic [15:0] target_handle;
    logic [31:0] sent_at;
    logic [31:0] retry_at;
    logic [2:0]  tries;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/ack_retry_tracker_top.sv =====
`timescale 1ns / 1ps
// Top level of the acknowledgement retry tracker: command sequencer, valid bits,
// configuration registers. Depends on art_pkg and art_ram.
//
//  channel   ports                                   beat accepted when
//  --------  --------------------------------------  ------------------------------
//  input     start, busy, in_item                    start high and busy low
//  result    out_strobe, out_item                    every cycle out_strobe is high
//  config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite, pready
//            prdata, pready
//
// Every command sweeps the whole table through one RAM read port, one slot per
// cycle. Busy stays high from acceptance through the sweep and the finishing
// step, and the final result is accepted at the same edge at which the next
// command may be taken.
// Reset is synchronous: valid bits clear at once and the RAM contents are left
// as they are, since a slot is only ever read through its valid bit.
// Results of scan and drain appear at most one per cycle during the sweep, with
// the last one at the end. The receiver cannot stall, so each result is shown once.
module ack_retry_tracker_top
  import art_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int N_W    = $clog2(RESULT_CAP + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  // Control state.
  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic                   pip_v_r, pip_v_nxt;
  logic [ADDR_W-1:0]      pip_idx_r, pip_idx_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic                   match_f_r, match_f_nxt;
  logic                   free_f_r, free_f_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [N_W-1:0]         n_r, n_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic [2:0]             retry_limit_r;
  logic [15:0]            ack_timeout_r;

  // Payload registers.
  in_item_t               req_r, req_nxt;
  logic [ADDR_W-1:0]      match_idx_r, match_idx_nxt;
  logic [ADDR_W-1:0]      free_idx_r, free_idx_nxt;
  entry_t                 cap_r, cap_nxt;
  out_item_t              pend_r, pend_nxt;
  out_item_t              out_r, out_nxt;

  // RAM port signals.
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  entry_t                 wr_entry;
  entry_t                 rd_entry;
  logic [ENTRY_W-1:0]     rd_data;

  // Slot evaluation terms.
  logic                   slot_v;
  logic                   is_due, is_dead, is_old, hit;
  logic [2:0]             cnt_inc;
  logic [31:0]            age;
  logic [4:0]             total_sat;

  art_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (iss_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;
  assign pready     = 1'b1;

  // Configuration port: the register is picked by the word address bit alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_RETRY_LIMIT: retry_limit_r <= pwdata[2:0];
        REG_ACK_TIMEOUT: ack_timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RETRY_LIMIT: prdata = {29'd0, retry_limit_r};
      REG_ACK_TIMEOUT: prdata = {16'd0, ack_timeout_r};
      default:         prdata = 32'd0;
    endcase
  end

  // The shared slot unit: one entry per cycle is judged against the command.
  assign slot_v  = pip_v_r && valid_r[pip_idx_r];
  assign is_dead = (rd_entry.tries >= retry_limit_r);
  assign is_due  = !is_dead && (req_r.now_seconds >= rd_entry.retry_at);
  assign age     = req_r.now_seconds - rd_entry.sent_at;
  assign is_old  = (age > {16'd0, ack_timeout_r});
  assign hit     = slot_v && (n_r < N_W'(RESULT_CAP)) &&
                   (((req_r.command == CMD_SCAN) && is_due) ||
                    ((req_r.command == CMD_DRAIN) && is_dead));

  assign cnt_inc   = (cap_r.tries == 3'd7) ? 3'd7 : cap_r.tries + 3'd1;
  assign total_sat = (32'(total_r) > 32'd31) ? 5'd31 : 5'(total_r);

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    pip_v_nxt      = 1'b0;
    pip_idx_nxt    = pip_idx_r;
    valid_nxt      = valid_r;
    match_f_nxt    = match_f_r;
    free_f_nxt     = free_f_r;
    pend_v_nxt     = pend_v_r;
    n_nxt          = n_r;
    total_nxt      = total_r;
    out_strobe_nxt = 1'b0;
    req_nxt        = req_r;
    match_idx_nxt  = match_idx_r;
    free_idx_nxt   = free_idx_r;
    cap_nxt        = cap_r;
    pend_nxt       = pend_r;
    out_nxt        = '0;
    wr_en          = 1'b0;
    wr_addr        = match_f_r ? match_idx_r : free_idx_r;
    wr_entry       = cap_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt   = S_SWEEP;
          req_nxt     = in_item;
          iss_nxt     = '0;
          match_f_nxt = 1'b0;
          free_f_nxt  = 1'b0;
          pend_v_nxt  = 1'b0;
          n_nxt       = '0;
          total_nxt   = '0;
        end
      end

      S_SWEEP: begin
        if (iss_r < CNT_W'(TABLE_DEPTH)) begin
          pip_v_nxt   = 1'b1;
          pip_idx_nxt = iss_r[ADDR_W-1:0];
          iss_nxt     = iss_r + CNT_W'(1);
        end else if (!pip_v_r) begin
          state_nxt = S_FINISH;
        end

        if (pip_v_r) begin
          if (slot_v) begin
            total_nxt = total_r + CNT_W'(1);
          end
          if (slot_v && !match_f_r && (rd_entry.message_id == req_r.message_id)) begin
            match_f_nxt   = 1'b1;
            match_idx_nxt = pip_idx_r;
            cap_nxt       = rd_entry;
          end
          if (!valid_r[pip_idx_r] && !free_f_r) begin
            free_f_nxt   = 1'b1;
            free_idx_nxt = pip_idx_r;
          end
          if (hit) begin
            // The held result goes out now; the new one waits, since only the
            // end of the sweep tells which result is the last.
            out_strobe_nxt = pend_v_r;
            out_nxt        = pend_r;
            pend_v_nxt     = 1'b1;
            pend_nxt       = '0;
            pend_nxt.status            = ST_OK;
            pend_nxt.out_message_id    = rd_entry.message_id;
            pend_nxt.out_user_id       = rd_entry.user_id;
            pend_nxt.out_payload_ref   = rd_entry.payload_ref;
            pend_nxt.out_target_handle = rd_entry.target_handle;
            pend_nxt.out_tries         = rd_entry.tries;
            n_nxt = n_r + N_W'(1);
            if (req_r.command == CMD_DRAIN) begin
              valid_nxt[pip_idx_r] = 1'b0;
            end
          end
          if ((req_r.command == CMD_PURGE) && slot_v && is_dead && is_old) begin
            valid_nxt[pip_idx_r] = 1'b0;
          end
        end
      end

      S_FINISH: begin
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        out_nxt        = '0;
        out_nxt.last   = 1'b1;
        out_nxt.status = ST_OK;
        case (req_r.command)
          CMD_TRACK: begin
            if (match_f_r || free_f_r) begin
              wr_en                  = 1'b1;
              wr_entry.message_id    = req_r.message_id;
              wr_entry.user_id       = req_r.user_id;
              wr_entry.payload_ref   = req_r.payload_ref;
              wr_entry.target_handle = req_r.target_handle;
              wr_entry.sent_at       = req_r.now_seconds;
              wr_entry.retry_at      = req_r.now_seconds + 32'd1;
              wr_entry.tries         = 3'd0;
              valid_nxt[wr_addr]     = 1'b1;
            end else begin
              out_nxt.status = ST_FULL;
            end
          end
          CMD_ACK: begin
            if (match_f_r) begin
              valid_nxt[match_idx_r] = 1'b0;
            end else begin
              out_nxt.status = ST_NONE;
            end
          end
          CMD_RETRY: begin
            if (match_f_r) begin
              wr_en          = 1'b1;
              wr_entry.tries = cnt_inc;
              if (cnt_inc < retry_limit_r) begin
                wr_entry.retry_at = req_r.now_seconds + (32'd1 << cnt_inc);
              end
            end else begin
              out_nxt.status = ST_NONE;
            end
          end
          CMD_SCAN, CMD_DRAIN: begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b1;
            end else begin
              out_nxt.status = ST_NONE;
            end
          end
          CMD_COUNT: begin
            out_nxt.status        = ST_COUNT;
            out_nxt.pending_total = total_sat;
          end
          CMD_PURGE: out_nxt.status = ST_OK;
          default:   out_nxt.status = ST_NONE;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iss_r        <= '0;
      pip_v_r      <= 1'b0;
      pip_idx_r    <= '0;
      valid_r      <= '0;
      match_f_r    <= 1'b0;
      free_f_r     <= 1'b0;
      pend_v_r     <= 1'b0;
      n_r          <= '0;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_r        <= iss_nxt;
      pip_v_r      <= pip_v_nxt;
      pip_idx_r    <= pip_idx_nxt;
      valid_r      <= valid_nxt;
      match_f_r    <= match_f_nxt;
      free_f_r     <= free_f_nxt;
      pend_v_r     <= pend_v_nxt;
      n_r          <= n_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    cap_r       <= cap_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  // A command never yields more results than the cap allows.
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_W'(RESULT_CAP))
    else $error("result count beyond cap");

  // An accepted command keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // The final beat of a command comes only out of the finishing step.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |-> ($past(state_r) == S_FINISH))
    else $error("last beat outside finishing step");

  // The slot pipeline is empty whenever the block is idle.
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pip_v_r))
    else $error("slot pipeline active while idle");

endmodule

// ===== src/art_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
